@@ rtl/alrv_pkg.sv @@
// Package for the application-list reply validator.
// Holds field widths, the header layout and the fixed reply profile.
// No dependencies; every other rtl file imports it.
package alrv_pkg;

	localparam int DATA_W           = 8;
	localparam int LEN_W            = 16;
	localparam int MAX_DATAGRAM_DEF = 65535;
	localparam int HEADER_BYTES     = 40;
	localparam int FLAG_OFFSET      = 30;
	localparam int PROFILE_FIRST    = 2;
	localparam int PROFILE_LEN      = 6;
	localparam int PROFILE_IDX_W    = 3;

	typedef logic [DATA_W-1:0] data_t;

	// Expected value of header byte PROFILE_FIRST + idx.
	function automatic data_t profile_byte(input logic [PROFILE_IDX_W-1:0] idx);
		data_t val;
		case (idx)
			3'd0:    val = 8'h04;
			3'd1:    val = 8'h33;
			3'd2:    val = 8'h02;
			3'd3:    val = 8'hfd;
			3'd4:    val = 8'ha8;
			3'd5:    val = 8'he3;
			default: val = 8'h00;
		endcase
		return val;
	endfunction

endpackage

@@ rtl/alrv_if.sv @@
// Handshake channels of the application-list reply validator.
// alrv_byte_if carries datagram bytes, alrv_verdict_if carries verdicts.
// Depends on alrv_pkg for the byte width.
interface alrv_byte_if;
	import alrv_pkg::*;
	logic  valid;
	logic  ready;
	data_t data_byte;
	logic  last;

	modport source (output valid, data_byte, last, input ready);
	modport sink   (input valid, data_byte, last, output ready);
endinterface

interface alrv_verdict_if;
	logic valid;
	logic ready;
	logic accepted;

	modport source (output valid, accepted, input ready);
	modport sink   (input valid, accepted, output ready);
endinterface

@@ rtl/app_list_reply_validator_top.sv @@
// Top level of the application-list reply validator.
// Depends on alrv_pkg and on the channels in alrv_if.sv.

// The block checks one reply datagram that arrives one byte per transfer on
// byte_in, with last high on its final byte, and gives one transfer on
// verdict for every datagram: accepted is 1 when the declared little-endian
// length in bytes 0-1 equals the real byte count, the count lies between 40
// and MAX_DATAGRAM, bytes 2-7 match the fixed profile, byte 30 is 0 or 1, and
// either the datagram is exactly 40 bytes with byte 30 at 1 or every name
// from byte 40 on is non-empty and the final byte is NUL. A byte is
// captured in an input register; from there a single pass of compare
// logic updates the running counters and flags and, on the last byte,
// loads the verdict register. A new byte is taken every cycle; the only
// stall is a last byte whose verdict cannot enter the verdict register
// because the previous verdict has not been taken yet. Bytes beyond
// MAX_DATAGRAM are still taken but no longer checked, and the datagram is
// then rejected. After each verdict the state returns to its reset values
// for the next datagram.
module app_list_reply_validator_top #(
	parameter int MAX_DATAGRAM = alrv_pkg::MAX_DATAGRAM_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	alrv_byte_if.sink             byte_in,
	alrv_verdict_if.source        verdict
);
	import alrv_pkg::*;

	// Counter must hold the saturation value MAX_DATAGRAM + 1.
	localparam int CNT_W = $clog2(MAX_DATAGRAM + 2);
	localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;
	localparam logic [CNT_W-1:0] LIMIT      = CNT_W'(MAX_DATAGRAM + 1);
	localparam logic [CNT_W-1:0] MAX_CNT    = CNT_W'(MAX_DATAGRAM);
	localparam logic [CNT_W-1:0] HDR_CNT    = CNT_W'(HEADER_BYTES);
	localparam logic [CNT_W-1:0] FLAG_IDX   = CNT_W'(FLAG_OFFSET);
	localparam logic [CNT_W-1:0] PROF_LO    = CNT_W'(PROFILE_FIRST);
	localparam logic [CNT_W-1:0] PROF_HI    = CNT_W'(PROFILE_FIRST + PROFILE_LEN);

	// Input register.
	logic  valid_s1;
	data_t byte_s1;
	logic  last_s1;

	// Running state of the datagram being checked.
	logic [CNT_W-1:0] byte_count_q, byte_count_d;
	logic [LEN_W-1:0] declared_length_q, declared_length_d;
	logic             header_ok_q, header_ok_d;
	logic             final_flag_q, final_flag_d;
	logic             at_name_start_q, at_name_start_d;
	logic             name_error_q, name_error_d;
	logic             prev_was_nul_q, prev_was_nul_d;

	// Verdict register.
	logic out_valid_q;
	logic accepted_q;

	logic                     go_s1;
	logic                     is_nul;
	logic [CNT_W-1:0]         prof_off;
	logic                     ok;

	// The stage moves unless a verdict is due and the verdict register is full
	// and not being emptied in this cycle.
	assign go_s1         = valid_s1 && (!last_s1 || !out_valid_q || verdict.ready);
	assign byte_in.ready = !valid_s1 || go_s1;

	assign verdict.valid    = out_valid_q;
	assign verdict.accepted = accepted_q;

	assign is_nul   = (byte_s1 == '0);
	assign prof_off = byte_count_q - PROF_LO;

	always_comb begin
		byte_count_d      = byte_count_q;
		declared_length_d = declared_length_q;
		header_ok_d       = header_ok_q;
		final_flag_d      = final_flag_q;
		at_name_start_d   = at_name_start_q;
		name_error_d      = name_error_q;
		prev_was_nul_d    = prev_was_nul_q;

		if (byte_count_q != LIMIT) begin
			if (byte_count_q == '0) begin
				declared_length_d = {{(LEN_W-DATA_W){1'b0}}, byte_s1};
			end else if (byte_count_q == CNT_W'(1)) begin
				declared_length_d = {byte_s1, declared_length_q[DATA_W-1:0]};
			end else if (byte_count_q >= PROF_LO && byte_count_q < PROF_HI) begin
				if (byte_s1 != profile_byte(prof_off[PROFILE_IDX_W-1:0])) begin
					header_ok_d = 1'b0;
				end
			end else if (byte_count_q == FLAG_IDX) begin
				if (byte_s1 > data_t'(1)) begin
					header_ok_d = 1'b0;
				end
				final_flag_d = (byte_s1 == data_t'(1));
			end else if (byte_count_q >= HDR_CNT) begin
				// An empty name is a NUL where a name should begin.
				if (is_nul && at_name_start_q) begin
					name_error_d = 1'b1;
				end
				at_name_start_d = is_nul;
			end
			prev_was_nul_d = is_nul;
			byte_count_d   = byte_count_q + CNT_W'(1);
		end

		// Verdict from the state after this byte.
		ok = (byte_count_d >= HDR_CNT) && (byte_count_d <= MAX_CNT)
			&& (CMP_W'(declared_length_d) == CMP_W'(byte_count_d)) && header_ok_d;
		if (ok) begin
			if (byte_count_d == HDR_CNT) begin
				ok = final_flag_d;
			end else begin
				ok = !name_error_d && prev_was_nul_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_in.ready) begin
			valid_s1 <= byte_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_in.ready) begin
			byte_s1 <= byte_in.data_byte;
			last_s1 <= byte_in.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q      <= '0;
			declared_length_q <= '0;
			header_ok_q       <= 1'b1;
			final_flag_q      <= 1'b0;
			at_name_start_q   <= 1'b1;
			name_error_q      <= 1'b0;
			prev_was_nul_q    <= 1'b0;
		end else if (go_s1) begin
			if (last_s1) begin
				// Datagram done: back to the starting state.
				byte_count_q      <= '0;
				declared_length_q <= '0;
				header_ok_q       <= 1'b1;
				final_flag_q      <= 1'b0;
				at_name_start_q   <= 1'b1;
				name_error_q      <= 1'b0;
				prev_was_nul_q    <= 1'b0;
			end else begin
				byte_count_q      <= byte_count_d;
				declared_length_q <= declared_length_d;
				header_ok_q       <= header_ok_d;
				final_flag_q      <= final_flag_d;
				at_name_start_q   <= at_name_start_d;
				name_error_q      <= name_error_d;
				prev_was_nul_q    <= prev_was_nul_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (verdict.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && last_s1) begin
			accepted_q <= ok;
		end
	end

endmodule
